// ===== sv/rjps_pkg.sv =====
// Shared types and constants for the range-jump point segmenter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rjps_pkg;

  localparam int MinPointsBits = 13;
  localparam int RatioBits     = 16;
  localparam int JumpMinBits   = 20;
  localparam int GapBits       = 20;
  localparam int ExtentFloor   = 102;  // 0.1 m in 1/1024 m units

  localparam int CfgAddrBits   = 4;
  localparam int CfgDataBits   = 32;

  typedef enum logic [1:0] {
    REG_MIN_POINTS = 2'd0,
    REG_JUMP_RATIO = 2'd1,
    REG_JUMP_MIN   = 2'd2,
    REG_GAP_ABS    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MinPointsBits-1:0] min_points;
    logic [RatioBits-1:0]     jump_ratio;
    logic [JumpMinBits-1:0]   jump_min;
    logic [GapBits-1:0]       gap_abs;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_X     = 3'd0,
    MUL_Y     = 3'd1,
    MUL_DX    = 3'd2,
    MUL_DY    = 3'd3,
    MUL_RATIO = 3'd4,
    MUL_THR   = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     rad_load;
    logic     sqrt_step;
    logic     d2_load;
    logic     thr_load;
    logic     div_start;
    logic     div_step;
    logic     load_out;
    logic     eos;
    logic     clr_cluster;
    logic     add_point;
    logic     clr_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic split;
    logic report;
    logic out_free;
    logic have_prev;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/range_jump_point_segmenter.sv =====
// Range-jump point segmenter, top level: config registers, controller and
// datapath. Depends on rjps_pkg, rjps_regs, rjps_ctrl, rjps_dp.
//
// Points are taken one at a time: in_stall stays high until the current
// point is through. The range square root resolves one bit per cycle and
// six squares/products go through one shared multiplier. The first point of
// a scan skips the jump test. Each reported cluster also runs the bit-serial
// centroid dividers (x and y run side by side), plus any wait on out_stall.
// A finished word sits in the output register while the next point is taken.
`timescale 1ns / 1ps
`default_nettype none
module range_jump_point_segmenter #(
  parameter int MAX_CLUSTER_POINTS = 4096,
  parameter int COORD_BITS         = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [rjps_pkg::CfgAddrBits-1:0]        paddr,
  input  logic [rjps_pkg::CfgDataBits-1:0]        pwdata,
  output logic [rjps_pkg::CfgDataBits-1:0]        prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [COORD_BITS-1:0]            point_x,
  input  logic signed [COORD_BITS-1:0]            point_y,
  input  logic                                    last_in_scan,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [COORD_BITS-1:0]            centroid_x,
  output logic signed [COORD_BITS-1:0]            centroid_y,
  output logic [COORD_BITS-1:0]                   extent_x,
  output logic [COORD_BITS-1:0]                   extent_y,
  output logic [$clog2(MAX_CLUSTER_POINTS+1)-1:0] point_count,
  output logic                                    end_of_scan,
  output logic                                    overflow
);
  import rjps_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rjps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rjps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rjps_dp #(
    .MAX_CLUSTER_POINTS (MAX_CLUSTER_POINTS),
    .COORD_BITS         (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_in_scan (last_in_scan),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .extent_x     (extent_x),
    .extent_y     (extent_y),
    .point_count  (point_count),
    .end_of_scan  (end_of_scan),
    .overflow     (overflow)
  );

endmodule
`default_nettype wire

// ===== sv/rjps_regs.sv =====
// APB-style configuration registers of the segmenter.
// Depends on rjps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjps_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rjps_pkg::CfgAddrBits-1:0] paddr,
  input  logic [rjps_pkg::CfgDataBits-1:0] pwdata,
  output logic [rjps_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready,
  output rjps_pkg::cfg_t                  cfg
);
  import rjps_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_points <= MinPointsBits'(3);
      cfg.jump_ratio <= RatioBits'(6554);
      cfg.jump_min   <= JumpMinBits'(51);
      cfg.gap_abs    <= GapBits'(512);
    end else if (wr_en) begin
      case (idx)
        REG_MIN_POINTS: cfg.min_points <= pwdata[MinPointsBits-1:0];
        REG_JUMP_RATIO: cfg.jump_ratio <= pwdata[RatioBits-1:0];
        REG_JUMP_MIN:   cfg.jump_min   <= pwdata[JumpMinBits-1:0];
        REG_GAP_ABS:    cfg.gap_abs    <= pwdata[GapBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_POINTS: prdata = CfgDataBits'(cfg.min_points);
      REG_JUMP_RATIO: prdata = CfgDataBits'(cfg.jump_ratio);
      REG_JUMP_MIN:   prdata = CfgDataBits'(cfg.jump_min);
      REG_GAP_ABS:    prdata = CfgDataBits'(cfg.gap_abs);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rjps_ctrl.sv =====
// Sequencing state machine of the segmenter: drives datapath commands.
// Depends on rjps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rjps_pkg::dp_stat_t stat,
  output rjps_pkg::dp_cmd_t  cmd
);
  import rjps_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_MX   = 16'h0002,
    S_MY   = 16'h0004,
    S_RAD  = 16'h0008,
    S_SQRT = 16'h0010,
    S_DX   = 16'h0020,
    S_DY   = 16'h0040,
    S_D2   = 16'h0080,
    S_THR  = 16'h0100,
    S_TSQ  = 16'h0200,
    S_CMP  = 16'h0400,
    S_CHK  = 16'h0800,
    S_DIV  = 16'h1000,
    S_EMIT = 16'h2000,
    S_CLR  = 16'h4000,
    S_ADD  = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   eos_phase, eos_phase_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eos_phase <= 1'b0;
    end else begin
      state     <= state_next;
      eos_phase <= eos_phase_next;
    end
  end

  always_comb begin
    state_next     = state;
    eos_phase_next = eos_phase;
    cmd            = '0;
    cmd.mul_sel    = MUL_X;
    cmd.eos        = eos_phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in   = 1'b1;
          eos_phase_next = 1'b0;
          state_next     = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_next  = S_MY;
      end
      S_MY: begin
        cmd.acc_load = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_Y;
        state_next   = S_RAD;
      end
      S_RAD: begin
        cmd.rad_load = 1'b1;
        state_next   = S_SQRT;
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_next = stat.have_prev ? S_DX : S_ADD;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DX: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_DX;
        state_next  = S_DY;
      end
      S_DY: begin
        cmd.acc_load = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_DY;
        state_next   = S_D2;
      end
      S_D2: begin
        cmd.d2_load = 1'b1;
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_RATIO;
        state_next  = S_THR;
      end
      S_THR: begin
        cmd.thr_load = 1'b1;
        state_next   = S_TSQ;
      end
      S_TSQ: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_THR;
        state_next  = S_CMP;
      end
      S_CMP: begin
        state_next = stat.split ? S_CHK : S_ADD;
      end
      S_CHK: begin
        if (stat.report) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_CLR;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_cluster = 1'b1;
        if (eos_phase) begin
          cmd.clr_prev = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_point = 1'b1;
        if (stat.last) begin
          eos_phase_next = 1'b1;
          state_next     = S_CHK;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rjps_dp.sv =====
// Datapath of the segmenter: shared multiplier, iterative square root,
// two iterative dividers, cluster accumulators and the output register.
// Depends on rjps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjps_dp #(
  parameter int MAX_CLUSTER_POINTS = 4096,
  parameter int COORD_BITS         = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  rjps_pkg::cfg_t                              cfg,
  input  rjps_pkg::dp_cmd_t                           cmd,
  output rjps_pkg::dp_stat_t                          stat,
  input  logic signed [COORD_BITS-1:0]                point_x,
  input  logic signed [COORD_BITS-1:0]                point_y,
  input  logic                                        last_in_scan,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [COORD_BITS-1:0]                centroid_x,
  output logic signed [COORD_BITS-1:0]                centroid_y,
  output logic [COORD_BITS-1:0]                       extent_x,
  output logic [COORD_BITS-1:0]                       extent_y,
  output logic [$clog2(MAX_CLUSTER_POINTS+1)-1:0]     point_count,
  output logic                                        end_of_scan,
  output logic                                        overflow
);
  import rjps_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int NW   = $clog2(MAX_CLUSTER_POINTS + 1);
  localparam int SW   = CW + NW;
  localparam int MW   = (CW > JumpMinBits) ? CW : JumpMinBits;
  localparam int PW   = (NW > MinPointsBits) ? NW : MinPointsBits;
  localparam int CNTW = $clog2(SW + 1);

  // current word
  logic signed [CW-1:0] cur_x, cur_y;
  logic                 cur_last;
  // previous point
  logic signed [CW-1:0] prev_x, prev_y;
  logic [CW-1:0]        prev_range;
  logic                 have_prev;
  // cluster accumulators
  logic [NW-1:0]        run_count;
  logic signed [SW-1:0] sum_x_acc, sum_y_acc;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                 count_overflowed;
  // multiplier
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      prod, acc;
  // square root
  logic [2*CW-1:0]      rad;
  logic [CW:0]          sq_rem;
  logic [CW-1:0]        root;
  logic [CW+2:0]        sq_sh, sq_trial;
  logic [CNTW-1:0]      iter;
  // jump test
  logic [2*CW:0]        d2;
  logic [MW-1:0]        thr;
  logic [CW-1:0]        rmin, rdiff, ratio_q;
  logic signed [CW:0]   dx, dy;
  // dividers
  logic [SW-1:0]        qx, qy;
  logic [NW-1:0]        remx, remy;
  logic [NW:0]          rsx, rsy;
  logic                 neg_x, neg_y;
  logic [SW-1:0]        magsx, magsy;
  logic [CW-1:0]        cx_mag, cy_mag;
  logic [CW:0]          ext_x_w, ext_y_w;
  logic [CW-1:0]        ext_x, ext_y;
  logic [CW-1:0]        most_pos;

  assign most_pos = {1'b0, {(CW-1){1'b1}}};

  function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
    logic [CW-1:0] r;
    r = v[CW-1] ? CW'(-v) : CW'(v);
    return r;
  endfunction

  function automatic logic [CW-1:0] mag_d(input logic signed [CW:0] v);
    logic [CW:0] r;
    r = v[CW] ? -v : v;
    return r[CW-1:0];
  endfunction

  assign dx = {cur_x[CW-1], cur_x} - {prev_x[CW-1], prev_x};
  assign dy = {cur_y[CW-1], cur_y} - {prev_y[CW-1], prev_y};

  always_comb begin
    case (cmd.mul_sel)
      MUL_X:     begin mul_a = MW'(mag_c(cur_x)); mul_b = MW'(mag_c(cur_x)); end
      MUL_Y:     begin mul_a = MW'(mag_c(cur_y)); mul_b = MW'(mag_c(cur_y)); end
      MUL_DX:    begin mul_a = MW'(mag_d(dx));    mul_b = MW'(mag_d(dx));    end
      MUL_DY:    begin mul_a = MW'(mag_d(dy));    mul_b = MW'(mag_d(dy));    end
      MUL_RATIO: begin mul_a = MW'(cfg.jump_ratio); mul_b = MW'(rmin);       end
      MUL_THR:   begin mul_a = thr;               mul_b = thr;               end
      default:   begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  // range test terms; root holds the current point's range after the sqrt
  assign rmin    = (root < prev_range) ? root : prev_range;
  assign rdiff   = (root > prev_range) ? root - prev_range : prev_range - root;
  assign ratio_q = prod[CW+15:16];

  assign sq_sh    = {sq_rem, rad[2*CW-1 -: 2]};
  assign sq_trial = (CW+3)'({root, 2'b01});

  assign rsx = {remx, qx[SW-1]};
  assign rsy = {remy, qy[SW-1]};

  assign magsx = sum_x_acc[SW-1] ? SW'(-sum_x_acc) : SW'(sum_x_acc);
  assign magsy = sum_y_acc[SW-1] ? SW'(-sum_y_acc) : SW'(sum_y_acc);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_x    <= point_x;
      cur_y    <= point_y;
      cur_last <= last_in_scan;
    end
    if (cmd.mul_go) prod <= mul_a * mul_b;
    if (cmd.acc_load) acc <= prod;
    if (cmd.rad_load) begin
      rad    <= acc[2*CW-1:0] + prod[2*CW-1:0];
      sq_rem <= '0;
      root   <= '0;
      iter   <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[2*CW-3:0], 2'b00};
      iter <= iter + 1'b1;
      if (sq_sh >= sq_trial) begin
        sq_rem <= (CW+1)'(sq_sh - sq_trial);
        root   <= {root[CW-2:0], 1'b1};
      end else begin
        sq_rem <= sq_sh[CW:0];
        root   <= {root[CW-2:0], 1'b0};
      end
    end else if (cmd.div_start) begin
      iter <= '0;
    end else if (cmd.div_step) begin
      iter <= iter + 1'b1;
    end
    if (cmd.d2_load) d2 <= (2*CW+1)'(acc) + (2*CW+1)'(prod);
    if (cmd.thr_load) begin
      thr <= (MW'(ratio_q) < MW'(cfg.jump_min)) ? MW'(cfg.jump_min) : MW'(ratio_q);
    end
    if (cmd.div_start) begin
      // rounded division: (|sum| + n/2) / n
      qx    <= magsx + SW'(run_count >> 1);
      qy    <= magsy + SW'(run_count >> 1);
      remx  <= '0;
      remy  <= '0;
      neg_x <= sum_x_acc[SW-1];
      neg_y <= sum_y_acc[SW-1];
    end else if (cmd.div_step) begin
      if (rsx >= (NW+1)'(run_count)) begin
        remx <= NW'(rsx - (NW+1)'(run_count));
        qx   <= {qx[SW-2:0], 1'b1};
      end else begin
        remx <= rsx[NW-1:0];
        qx   <= {qx[SW-2:0], 1'b0};
      end
      if (rsy >= (NW+1)'(run_count)) begin
        remy <= NW'(rsy - (NW+1)'(run_count));
        qy   <= {qy[SW-2:0], 1'b1};
      end else begin
        remy <= rsy[NW-1:0];
        qy   <= {qy[SW-2:0], 1'b0};
      end
    end
  end

  // previous point and cluster state
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_prev) begin
      prev_x     <= '0;
      prev_y     <= '0;
      prev_range <= '0;
      have_prev  <= 1'b0;
    end else if (cmd.add_point) begin
      prev_x     <= cur_x;
      prev_y     <= cur_y;
      prev_range <= root;
      have_prev  <= 1'b1;
    end
    if (rst || cmd.clr_cluster) begin
      run_count        <= '0;
      sum_x_acc        <= '0;
      sum_y_acc        <= '0;
      lo_x             <= most_pos;
      lo_y             <= most_pos;
      hi_x             <= ~most_pos;
      hi_y             <= ~most_pos;
      count_overflowed <= 1'b0;
    end else if (cmd.add_point) begin
      if (run_count == NW'(MAX_CLUSTER_POINTS)) begin
        count_overflowed <= 1'b1;
      end else begin
        run_count <= run_count + 1'b1;
        sum_x_acc <= sum_x_acc + {{(SW-CW){cur_x[CW-1]}}, cur_x};
        sum_y_acc <= sum_y_acc + {{(SW-CW){cur_y[CW-1]}}, cur_y};
        if (cur_x < lo_x) lo_x <= cur_x;
        if (cur_x > hi_x) hi_x <= cur_x;
        if (cur_y < lo_y) lo_y <= cur_y;
        if (cur_y > hi_y) hi_y <= cur_y;
      end
    end
  end

  assign ext_x_w = {hi_x[CW-1], hi_x} - {lo_x[CW-1], lo_x};
  assign ext_y_w = {hi_y[CW-1], hi_y} - {lo_y[CW-1], lo_y};
  assign ext_x   = (ext_x_w[CW-1:0] < CW'(ExtentFloor)) ? CW'(ExtentFloor) : ext_x_w[CW-1:0];
  assign ext_y   = (ext_y_w[CW-1:0] < CW'(ExtentFloor)) ? CW'(ExtentFloor) : ext_y_w[CW-1:0];
  assign cx_mag  = qx[CW-1:0];
  assign cy_mag  = qy[CW-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      centroid_x  <= neg_x ? -cx_mag : cx_mag;
      centroid_y  <= neg_y ? -cy_mag : cy_mag;
      extent_x    <= ext_x;
      extent_y    <= ext_y;
      point_count <= run_count;
      end_of_scan <= cmd.eos;
      overflow    <= count_overflowed;
    end
  end

  assign stat.sqrt_done = (iter == CNTW'(CW));
  assign stat.div_done  = (iter == CNTW'(SW));
  assign stat.split     = ((2*MW+1)'(d2) > (2*MW+1)'(prod)) ||
                          (MW'(rdiff) > MW'(cfg.gap_abs));
  assign stat.report    = (run_count != '0) && (PW'(run_count) >= PW'(cfg.min_points));
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.have_prev = have_prev;
  assign stat.last      = cur_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= NW'(MAX_CLUSTER_POINTS))
    else $error("cluster count above bound");

  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> point_count == NW'(MAX_CLUSTER_POINTS))
    else $error("overflow flagged on unsaturated count");

  a_extent_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (extent_x >= CW'(ExtentFloor)) && (extent_y >= CW'(ExtentFloor)))
    else $error("extent below floor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || !out_stall)
    else $error("output word overwritten while held");

endmodule
`default_nettype wire
